// ===== sv/scd_pkg.sv =====
package scd_pkg;

   localparam int ANGLE_BITS      = 16;
   localparam int VOLT_BITS       = 16;
   localparam int DUTY_FIELD_BITS = 8;

   localparam logic [VOLT_BITS-1:0] BUS_RESET = 16'd12000;

   // pi/2 in Q2.30 and sqrt(3) in Q16
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam logic signed [49:0] SQRT3_Q16 = 50'sd113512;

   // clamped voltage (half-millivolt units) and signed Q1.15 sine/cosine
   typedef struct packed {
      logic signed [17:0] uq2;
      logic signed [15:0] sine;
      logic signed [15:0] cosine;
      logic               clip;
   } wave_type;

   // Quarter-wave entry r of 2^qbits steps: Q2.30 Taylor series, scaled to 32767
   function automatic logic [14:0] sine_entry(input int unsigned r, input int unsigned qbits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      x    = (64'(r) * HALF_PI_Q30) >> qbits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - signed'(term);
      if (sum < 0) begin
         sum = 0;
      end
      v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return 15'(v);
   endfunction

endpackage

// ===== sv/scd_channels.sv =====
interface scd_req_if import scd_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [ANGLE_BITS-1:0]       electrical_angle;
   logic signed [VOLT_BITS-1:0] quadrature_millivolts;

   modport source (output valid, electrical_angle, quadrature_millivolts, input ready);
   modport sink   (input valid, electrical_angle, quadrature_millivolts, output ready);
endinterface

interface scd_rsp_if import scd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [DUTY_FIELD_BITS-1:0] duty_phase_a;
   logic [DUTY_FIELD_BITS-1:0] duty_phase_b;
   logic [DUTY_FIELD_BITS-1:0] duty_phase_c;
   logic                       voltage_clipped;

   modport source (output valid, duty_phase_a, duty_phase_b, duty_phase_c, voltage_clipped,
                   input ready);
   modport sink   (input valid, duty_phase_a, duty_phase_b, duty_phase_c, voltage_clipped,
                   output ready);
endinterface

// ===== sv/sine_commutation_duty_unit.sv =====
// channel   direction  payload                                        transfer when
// req_chan  in         electrical_angle, quadrature_millivolts        valid && ready
// rsp_chan  out        duty_phase_a/b/c, voltage_clipped              valid && ready
// csr_*     in         csr_write_data (bus millivolts)                csr_write_enable
//
// Two stages of clamp and sine table, four of multiply, sum and scale, and
// one per duty bit in the divider. One item per cycle is sustained while
// the output is not stalled; the per-bit divider stages set the depth.
// Reset clears every stage's valid bit and loads 12000 mV into the bus register.
// A stage advances when it is empty or the one after it is advancing, so a stalled
// output holds its result while bubbles further up still close.
module sine_commutation_duty_unit import scd_pkg::*; #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int DUTY_BITS       = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   scd_req_if.sink              req_chan,
   scd_rsp_if.source            rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [VOLT_BITS-1:0] csr_write_data
);

   localparam int SW = VOLT_BITS + DUTY_BITS;

   logic [VOLT_BITS-1:0] vbus_ff;

   logic                 wave_valid;
   logic                 wave_ready;
   wave_type             wave_data;

   logic                 xf_valid;
   logic                 xf_ready;
   logic [SW-1:0]        xf_scaled_a;
   logic [SW-1:0]        xf_scaled_b;
   logic [SW-1:0]        xf_scaled_c;
   logic                 xf_clip;

   logic [DUTY_BITS-1:0] quot_a;
   logic [DUTY_BITS-1:0] quot_b;
   logic [DUTY_BITS-1:0] quot_c;
   logic                 bus_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         vbus_ff <= BUS_RESET;
      end else if (csr_write_enable) begin
         vbus_ff <= csr_write_data;
      end
   end

   scd_wave #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_wave (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .angle     (req_chan.electrical_angle),
      .uq        (req_chan.quadrature_millivolts),
      .vbus      (vbus_ff),
      .out_valid (wave_valid),
      .out_ready (wave_ready),
      .out_data  (wave_data)
   );

   scd_xform #(
      .DUTY_BITS (DUTY_BITS)
   ) u_xform (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (wave_valid),
      .in_ready     (wave_ready),
      .in_data      (wave_data),
      .vbus         (vbus_ff),
      .out_valid    (xf_valid),
      .out_ready    (xf_ready),
      .out_scaled_a (xf_scaled_a),
      .out_scaled_b (xf_scaled_b),
      .out_scaled_c (xf_scaled_c),
      .out_clip     (xf_clip)
   );

   scd_divide #(
      .DUTY_BITS (DUTY_BITS)
   ) u_divide (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (xf_valid),
      .in_ready    (xf_ready),
      .in_scaled_a (xf_scaled_a),
      .in_scaled_b (xf_scaled_b),
      .in_scaled_c (xf_scaled_c),
      .in_clip     (xf_clip),
      .vbus        (vbus_ff),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_quot_a  (quot_a),
      .out_quot_b  (quot_b),
      .out_quot_c  (quot_c),
      .out_clip    (rsp_chan.voltage_clipped)
   );

   // no bus voltage: the divider sees a zero divisor, force the duties off
   assign bus_zero = (vbus_ff == '0);

   assign rsp_chan.duty_phase_a = bus_zero ? '0 : DUTY_FIELD_BITS'(quot_a);
   assign rsp_chan.duty_phase_b = bus_zero ? '0 : DUTY_FIELD_BITS'(quot_b);
   assign rsp_chan.duty_phase_c = bus_zero ? '0 : DUTY_FIELD_BITS'(quot_c);

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.ready |-> req_chan.ready)
      else $error("input stalled while the output side is taking results");

   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("input stalled with an empty output stage");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result presented right after reset");

endmodule

// ===== sv/scd_wave.sv =====
module scd_wave import scd_pkg::*; #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [ANGLE_BITS-1:0]       angle,
   input  logic signed [VOLT_BITS-1:0] uq,
   input  logic [VOLT_BITS-1:0]        vbus,
   output logic                        out_valid,
   input  logic                        out_ready,
   output wave_type                    out_data
);

   localparam int QB   = SINE_TABLE_BITS - 2;
   localparam int QLEN = 1 << QB;
   localparam int AW   = QB + 1;

   typedef logic [14:0] rom_type [QLEN+1];

   function automatic rom_type build_rom();
      rom_type t;
      for (int r = 0; r <= QLEN; r++) begin
         t[r] = sine_entry(r, QB);
      end
      return t;
   endfunction

   localparam rom_type ROM = build_rom();

   logic [SINE_TABLE_BITS-1:0] idx;
   logic [1:0]                 squad;
   logic [1:0]                 cquad;
   logic [QB-1:0]              ridx;
   logic [AW-1:0]              saddr_in;
   logic [AW-1:0]              caddr_in;
   logic signed [17:0]         uq2_raw;
   logic signed [17:0]         vpos;
   logic signed [17:0]         uq2_in;
   logic                       clip_in;
   logic                       en1;
   logic                       en2;

   logic                       v1_ff;
   logic signed [17:0]         uq2_ff;
   logic                       clip_ff;
   logic [AW-1:0]              saddr_ff;
   logic [AW-1:0]              caddr_ff;
   logic                       sneg_ff;
   logic                       cneg_ff;

   logic signed [15:0]         sval;
   logic signed [15:0]         cval;
   wave_type                   wave_in;
   logic                       v2_ff;
   wave_type                   wave_ff;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // quadrant folding: odd quadrants read the table backward, upper half negates
   assign idx   = angle[ANGLE_BITS-1 -: SINE_TABLE_BITS];
   assign squad = idx[SINE_TABLE_BITS-1 -: 2];
   assign cquad = squad + 2'd1;
   assign ridx  = idx[QB-1:0];

   assign saddr_in = squad[0] ? AW'(QLEN) - {1'b0, ridx} : {1'b0, ridx};
   assign caddr_in = cquad[0] ? AW'(QLEN) - {1'b0, ridx} : {1'b0, ridx};

   assign uq2_raw = signed'({uq[VOLT_BITS-1], uq, 1'b0});
   assign vpos    = signed'({2'b00, vbus});

   always_comb begin
      priority if (uq2_raw > vpos) begin
         uq2_in  = vpos;
         clip_in = 1'b1;
      end else if (uq2_raw < -vpos) begin
         uq2_in  = -vpos;
         clip_in = 1'b1;
      end else begin
         uq2_in  = uq2_raw;
         clip_in = 1'b0;
      end
   end

   assign sval = signed'({1'b0, ROM[saddr_ff]});
   assign cval = signed'({1'b0, ROM[caddr_ff]});

   always_comb begin
      wave_in.uq2    = uq2_ff;
      wave_in.sine   = sneg_ff ? -sval : sval;
      wave_in.cosine = cneg_ff ? -cval : cval;
      wave_in.clip   = clip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
      if (en1) begin
         uq2_ff   <= uq2_in;
         clip_ff  <= clip_in;
         saddr_ff <= saddr_in;
         caddr_ff <= caddr_in;
         sneg_ff  <= squad[1];
         cneg_ff  <= cquad[1];
      end
      if (en2) begin
         wave_ff <= wave_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = wave_ff;

endmodule

// ===== sv/scd_xform.sv =====
module scd_xform import scd_pkg::*; #(
   parameter int DUTY_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  wave_type                      in_data,
   input  logic [VOLT_BITS-1:0]          vbus,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [VOLT_BITS+DUTY_BITS-1:0] out_scaled_a,
   output logic [VOLT_BITS+DUTY_BITS-1:0] out_scaled_b,
   output logic [VOLT_BITS+DUTY_BITS-1:0] out_scaled_c,
   output logic                          out_clip
);

   localparam int SW = VOLT_BITS + DUTY_BITS;
   localparam int UW = 49;
   localparam int MW = UW + DUTY_BITS;

   logic en3;
   logic en4;
   logic en5;
   logic en6;

   // multiply
   logic signed [33:0] ps_in;
   logic signed [33:0] pc_in;
   logic               v3_ff;
   logic signed [33:0] ps_ff;
   logic signed [33:0] pc_ff;
   logic               clip3_ff;

   // sqrt3 scaling
   logic signed [49:0] b3_in;
   logic               v4_ff;
   logic signed [33:0] ps4_ff;
   logic signed [49:0] b3_ff;
   logic               clip4_ff;

   // phase sums and clamp to [0, vbus]
   logic signed [51:0] v2w;
   logic signed [51:0] topw;
   logic signed [51:0] psw16;
   logic signed [51:0] psw17;
   logic signed [51:0] b3w;
   logic signed [51:0] sum_in [3];
   logic [UW-1:0]      u_in [3];
   logic               v5_ff;
   logic [UW-1:0]      u_ff [3];
   logic               clip5_ff;

   // scale by 2^DUTY_BITS - 1, drop the fraction
   logic [MW-1:0]      prod [3];
   logic [SW-1:0]      scaled_in [3];
   logic               v6_ff;
   logic [SW-1:0]      scaled_ff [3];
   logic               clip6_ff;

   assign en6      = !v6_ff || out_ready;
   assign en5      = !v5_ff || en6;
   assign en4      = !v4_ff || en5;
   assign en3      = !v3_ff || en4;
   assign in_ready = en3;

   assign ps_in = 34'(in_data.uq2) * 34'(in_data.sine);
   assign pc_in = 34'(in_data.uq2) * 34'(in_data.cosine);

   assign b3_in = 50'(pc_ff) * SQRT3_Q16;

   always_comb begin
      v2w      = signed'({4'b0, vbus, 32'b0});
      topw     = signed'({3'b0, vbus, 33'b0});
      psw16    = 52'(ps4_ff) <<< 16;
      psw17    = 52'(ps4_ff) <<< 17;
      b3w      = 52'(b3_ff);
      sum_in[0] = v2w - psw17;
      sum_in[1] = v2w + b3w + psw16;
      sum_in[2] = v2w + psw16 - b3w;
      for (int k = 0; k < 3; k++) begin
         priority if (sum_in[k] < 0) begin
            u_in[k] = '0;
         end else if (sum_in[k] > topw) begin
            u_in[k] = UW'(topw);
         end else begin
            u_in[k] = UW'(sum_in[k]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod[k]      = {u_ff[k], {DUTY_BITS{1'b0}}} - MW'(u_ff[k]);
         scaled_in[k] = prod[k][MW-1:33];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en3) begin
            v3_ff <= in_valid;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
         if (en6) begin
            v6_ff <= v5_ff;
         end
      end
      if (en3) begin
         ps_ff    <= ps_in;
         pc_ff    <= pc_in;
         clip3_ff <= in_data.clip;
      end
      if (en4) begin
         ps4_ff   <= ps_ff;
         b3_ff    <= b3_in;
         clip4_ff <= clip3_ff;
      end
      if (en5) begin
         u_ff     <= u_in;
         clip5_ff <= clip4_ff;
      end
      if (en6) begin
         scaled_ff <= scaled_in;
         clip6_ff  <= clip5_ff;
      end
   end

   assign out_valid    = v6_ff;
   assign out_scaled_a = scaled_ff[0];
   assign out_scaled_b = scaled_ff[1];
   assign out_scaled_c = scaled_ff[2];
   assign out_clip     = clip6_ff;

endmodule

// ===== sv/scd_divide.sv =====
module scd_divide import scd_pkg::*; #(
   parameter int DUTY_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [VOLT_BITS+DUTY_BITS-1:0] in_scaled_a,
   input  logic [VOLT_BITS+DUTY_BITS-1:0] in_scaled_b,
   input  logic [VOLT_BITS+DUTY_BITS-1:0] in_scaled_c,
   input  logic                           in_clip,
   input  logic [VOLT_BITS-1:0]           vbus,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [DUTY_BITS-1:0]           out_quot_a,
   output logic [DUTY_BITS-1:0]           out_quot_b,
   output logic [DUTY_BITS-1:0]           out_quot_c,
   output logic                           out_clip
);

   localparam int SW = VOLT_BITS + DUTY_BITS;

   logic [DUTY_BITS:0]   en;
   logic [DUTY_BITS-1:0] src_v;
   logic [DUTY_BITS-1:0] src_clip;
   logic [SW-1:0]        src_rem [DUTY_BITS][3];
   logic [DUTY_BITS-1:0] src_quot [DUTY_BITS][3];
   logic [SW-1:0]        rem_in [DUTY_BITS][3];
   logic [DUTY_BITS-1:0] quot_in [DUTY_BITS][3];

   logic [DUTY_BITS-1:0] v_ff;
   logic [DUTY_BITS-1:0] clip_ff;
   logic [SW-1:0]        rem_ff [DUTY_BITS][3];
   logic [DUTY_BITS-1:0] quot_ff [DUTY_BITS][3];

   // each stage takes when it is empty or its successor takes
   always_comb begin
      en[DUTY_BITS] = out_ready;
      for (int j = DUTY_BITS - 1; j >= 0; j--) begin
         en[j] = !v_ff[j] || en[j+1];
      end
   end

   assign in_ready = en[0];

   if (DUTY_BITS > 1) begin : g_chain
      assign src_v    = {v_ff[DUTY_BITS-2:0], in_valid};
      assign src_clip = {clip_ff[DUTY_BITS-2:0], in_clip};
   end else begin : g_single
      assign src_v    = in_valid;
      assign src_clip = in_clip;
   end

   always_comb begin
      src_rem[0][0]  = in_scaled_a;
      src_rem[0][1]  = in_scaled_b;
      src_rem[0][2]  = in_scaled_c;
      for (int k = 0; k < 3; k++) begin
         src_quot[0][k] = '0;
      end
      for (int j = 1; j < DUTY_BITS; j++) begin
         src_rem[j]  = rem_ff[j-1];
         src_quot[j] = quot_ff[j-1];
      end
   end

   // restoring division, one quotient bit per stage, MSB first
   always_comb begin
      logic [SW-1:0] dsh;
      for (int j = 0; j < DUTY_BITS; j++) begin
         dsh = SW'(vbus) << (DUTY_BITS - 1 - j);
         for (int k = 0; k < 3; k++) begin
            if (src_rem[j][k] >= dsh) begin
               rem_in[j][k]  = src_rem[j][k] - dsh;
               quot_in[j][k] = src_quot[j][k] | (DUTY_BITS'(1) << (DUTY_BITS - 1 - j));
            end else begin
               rem_in[j][k]  = src_rem[j][k];
               quot_in[j][k] = src_quot[j][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int j = 0; j < DUTY_BITS; j++) begin
            if (en[j]) begin
               v_ff[j] <= src_v[j];
            end
         end
      end
      for (int j = 0; j < DUTY_BITS; j++) begin
         if (en[j]) begin
            clip_ff[j] <= src_clip[j];
            rem_ff[j]  <= rem_in[j];
            quot_ff[j] <= quot_in[j];
         end
      end
   end

   assign out_valid  = v_ff[DUTY_BITS-1];
   assign out_clip   = clip_ff[DUTY_BITS-1];
   assign out_quot_a = quot_ff[DUTY_BITS-1][0];
   assign out_quot_b = quot_ff[DUTY_BITS-1][1];
   assign out_quot_c = quot_ff[DUTY_BITS-1][2];

endmodule

// ===== sim/sine_commutation_duty_checker.sv =====
module sine_commutation_duty_checker import scd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   scd_req_if                   req_tap,
   scd_rsp_if                   rsp_tap,
   input  logic                 csr_write_enable,
   input  logic [VOLT_BITS-1:0] csr_write_data,
   output int                   mismatches,
   output int                   outstanding,
   output int                   results_checked,
   output int                   clamped_seen
);

   localparam int TABLE_BITS    = 10;
   localparam int DUTY_WIDTH    = 8;
   localparam int QUARTER_STEPS = 1 << (TABLE_BITS - 2);
   localparam longint DUTY_FULL = (longint'(1) << DUTY_WIDTH) - 1;

   typedef struct packed {
      logic [ANGLE_BITS-1:0]       angle;
      logic signed [VOLT_BITS-1:0] uq_mv;
      logic [VOLT_BITS-1:0]        vbus_mv;
      logic [DUTY_FIELD_BITS-1:0]  phase_a;
      logic [DUTY_FIELD_BITS-1:0]  phase_b;
      logic [DUTY_FIELD_BITS-1:0]  phase_c;
      logic                        clipped;
   } duty_expect_type;

   longint               quarter_sine [QUARTER_STEPS+1];
   duty_expect_type      expected_duties [$];
   logic [VOLT_BITS-1:0] bus_mv;

   // Q2.30 Taylor series of sin up to x^15, scaled to Q1.15 with round half up
   function automatic longint quarter_sine_entry(input int r);
      longint x, x2, term, acc, v;
      x    = (longint'(r) * longint'(HALF_PI_Q30)) / QUARTER_STEPS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      v = (acc * 32767 + (longint'(1) << 29)) >> 30;
      return (v > 32767) ? 32767 : v;
   endfunction

   function automatic longint table_sine(input logic [TABLE_BITS-1:0] idx);
      logic [1:0]            quad;
      logic [TABLE_BITS-3:0] step;
      longint                v;
      quad = idx[TABLE_BITS-1 -: 2];
      step = idx[TABLE_BITS-3:0];
      v    = quad[0] ? quarter_sine[QUARTER_STEPS - int'(step)] : quarter_sine[step];
      return quad[1] ? -v : v;
   endfunction

   // phase_sum carries the factor 2 of the halving and 2^32 of the table scaling
   function automatic logic [DUTY_FIELD_BITS-1:0] duty_of(input longint phase_sum,
                                                          input longint vbus);
      longint top, u, hi, lo;
      if (vbus == 0 || phase_sum <= 0) begin
         return '0;
      end
      top = vbus << 33;
      u   = (phase_sum > top) ? top : phase_sum;
      hi  = u >> 33;
      lo  = u & ((longint'(1) << 33) - 1);
      return DUTY_FIELD_BITS'((hi * DUTY_FULL + ((lo * DUTY_FULL) >> 33)) / vbus);
   endfunction

   function automatic duty_expect_type commutation_duty(
         input logic [ANGLE_BITS-1:0] angle,
         input logic signed [VOLT_BITS-1:0] uq_mv,
         input logic [VOLT_BITS-1:0] vbus_mv);
      duty_expect_type       d;
      longint                vbus, uq2, s, c, alpha, beta3, center;
      logic [TABLE_BITS-1:0] idx;
      vbus      = longint'(vbus_mv);
      uq2       = 2 * longint'(uq_mv);
      d.angle   = angle;
      d.uq_mv   = uq_mv;
      d.vbus_mv = vbus_mv;
      d.clipped = 1'b0;
      if (uq2 > vbus) begin
         uq2       = vbus;
         d.clipped = 1'b1;
      end else if (uq2 < -vbus) begin
         uq2       = -vbus;
         d.clipped = 1'b1;
      end
      idx    = angle[ANGLE_BITS-1 -: TABLE_BITS];
      s      = table_sine(idx);
      c      = table_sine(idx + TABLE_BITS'(QUARTER_STEPS));
      alpha  = -uq2 * s * 65536;
      beta3  = uq2 * c * longint'(SQRT3_Q16);
      center = vbus << 32;
      d.phase_a = duty_of(2 * alpha + center, vbus);
      d.phase_b = duty_of(beta3 - alpha + center, vbus);
      d.phase_c = duty_of(-alpha - beta3 + center, vbus);
      return d;
   endfunction

   task automatic flag(input string text);
      $display("[%0t] duty check: %s", $time, text);
      mismatches++;
   endtask

   initial begin
      for (int r = 0; r <= QUARTER_STEPS; r++) begin
         quarter_sine[r] = quarter_sine_entry(r);
      end
   end

   always @(posedge clock) begin
      duty_expect_type want;
      string           item;
      if (reset) begin
         bus_mv = BUS_RESET;
         expected_duties.delete();
         mismatches      = 0;
         results_checked = 0;
         clamped_seen    = 0;
      end else begin
         if (csr_write_enable) begin
            bus_mv = csr_write_data;
         end
         if (req_tap.valid && req_tap.ready) begin
            expected_duties.push_back(commutation_duty(req_tap.electrical_angle,
                                                       req_tap.quadrature_millivolts, bus_mv));
         end
         if (rsp_tap.valid && rsp_tap.ready) begin
            if (expected_duties.size() == 0) begin
               flag("result transfer with nothing outstanding");
            end else begin
               want = expected_duties.pop_front();
               item = $sformatf("angle %0d uq %0d bus %0d", want.angle, want.uq_mv,
                                want.vbus_mv);
               if (rsp_tap.duty_phase_a !== want.phase_a) begin
                  flag($sformatf("%s: phase A %0d, want %0d", item, rsp_tap.duty_phase_a,
                                 want.phase_a));
               end
               if (rsp_tap.duty_phase_b !== want.phase_b) begin
                  flag($sformatf("%s: phase B %0d, want %0d", item, rsp_tap.duty_phase_b,
                                 want.phase_b));
               end
               if (rsp_tap.duty_phase_c !== want.phase_c) begin
                  flag($sformatf("%s: phase C %0d, want %0d", item, rsp_tap.duty_phase_c,
                                 want.phase_c));
               end
               if (rsp_tap.voltage_clipped !== want.clipped) begin
                  flag($sformatf("%s: clipped %b, want %b", item, rsp_tap.voltage_clipped,
                                 want.clipped));
               end
               results_checked++;
               if (want.clipped) begin
                  clamped_seen++;
               end
            end
         end
      end
      outstanding <= expected_duties.size();
   end

endmodule

// ===== sim/sine_commutation_duty_unit_tb.sv =====
module sine_commutation_duty_unit_tb;
   import scd_pkg::*;

   localparam int PIPE_DEPTH      = 14;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int ITEMS_PER_PHASE = 168;
   localparam int RANDOM_PHASES   = 3;

   localparam int EDGE_UQ [10]   = '{0, 32767, -32768, 6000, 6001, -6000, -6001, 5999, -1, 1};
   localparam int EDGE_ANGLE [8] = '{0, 65535, 16384, 32768, 49152, 16320, 64, 10922};
   // zero bus, smallest and largest bus, back to default, odd small, top bit alone, odd large
   localparam int BUS_PLAN [7]   = '{0, 1, 65535, 12000, 3, 32768, 24001};

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [VOLT_BITS-1:0] csr_write_data;
   int                   mismatches;
   int                   outstanding;
   int                   results_checked;
   int                   clamped_seen;
   int                   cycle_count = 0;
   bit                   send_steady = 1'b0;

   scd_req_if req_link ();
   scd_rsp_if rsp_link ();

   sine_commutation_duty_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_link),
      .rsp_chan         (rsp_link),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   sine_commutation_duty_checker duty_check (
      .clock            (clock),
      .reset            (reset),
      .req_tap          (req_link),
      .rsp_tap          (rsp_link),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .results_checked  (results_checked),
      .clamped_seen     (clamped_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("sine_commutation_duty_unit_tb: done, errors");
      $finish;
   end

   // hold the valid high across back-to-back transfers; drop it only for a gap
   task automatic send_item(input int angle, input int uq);
      int gap;
      if ($urandom_range(0, 59) == 0) begin
         send_steady = !send_steady;
      end
      gap = send_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_link.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_link.valid                 <= 1'b1;
      req_link.electrical_angle      <= ANGLE_BITS'(angle);
      req_link.quadrature_millivolts <= VOLT_BITS'(uq);
      do @(posedge clock); while (!(req_link.valid && req_link.ready));
   endtask

   function automatic int pick_quadrature(input int vbus);
      int kind, half, uq;
      kind = $urandom_range(0, 9);
      half = vbus / 2;
      if (kind < 4) begin
         uq = int'($urandom_range(0, 65535)) - 32768;
      end else if (kind < 7) begin
         uq = int'($urandom_range(0, 2 * half)) - half;
      end else begin
         // straddle the clamp threshold on either side
         uq = half + int'($urandom_range(0, 2)) - 1;
         if ($urandom_range(0, 1)) begin
            uq = -uq;
         end
      end
      if (uq > 32767) begin
         uq = 32767;
      end else if (uq < -32768) begin
         uq = -32768;
      end
      return uq;
   endfunction

   task automatic random_items(input int vbus, input int count);
      int angle;
      for (int n = 0; n < count; n++) begin
         angle = $urandom_range(0, 65535);
         if ($urandom_range(0, 7) == 0) begin
            // land on a quadrant boundary of the table, or just below one
            angle = ($urandom_range(0, 3) << 14) - int'($urandom_range(0, 1)) * 64;
            angle = angle & 16'hFFFF;
         end
         send_item(angle, pick_quadrature(vbus));
      end
   endtask

   task automatic drain();
      req_link.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_bus(input int vbus);
      csr_write_data   <= VOLT_BITS'(vbus);
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // receiver: random stalls, steady stretches, two long hold-offs to back up the pipe
   initial begin
      int gap;
      int taken;
      bit steady;
      taken  = 0;
      steady = 1'b0;
      rsp_link.ready <= 1'b0;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 39) == 0) begin
            steady = !steady;
         end
         gap = steady ? 0 : $urandom_range(0, 9);
         if (taken == 300 || taken == 1200) begin
            gap = HOLD_OFF_CYCLES;
         end
         if (gap > 0) begin
            rsp_link.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_link.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_link.valid && rsp_link.ready));
         taken++;
      end
   end

   initial begin
      int vbus;
      int settings;
      reset                          <= 1'b1;
      req_link.valid                 <= 1'b0;
      req_link.electrical_angle      <= '0;
      req_link.quadrature_millivolts <= '0;
      csr_write_enable               <= 1'b0;
      csr_write_data                 <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default bus after reset: clamp edges, table quadrants, sign extremes
      vbus     = int'(BUS_RESET);
      settings = 1;
      for (int i = 0; i < 10; i++) begin
         send_item(EDGE_ANGLE[i % 8], EDGE_UQ[i]);
      end
      for (int i = 0; i < 8; i++) begin
         send_item(EDGE_ANGLE[i], 4000);
      end
      random_items(vbus, ITEMS_PER_PHASE);
      drain();

      for (int phase = 0; phase < 7 + RANDOM_PHASES; phase++) begin
         vbus = (phase < 7) ? BUS_PLAN[phase] : int'($urandom_range(1, 65535));
         set_bus(vbus);
         settings++;
         random_items(vbus, ITEMS_PER_PHASE);
         drain();
      end

      repeat (3 * PIPE_DEPTH) @(posedge clock);
      $display("checked %0d duty triples over %0d bus settings, %0d of them with Uq clamped",
               results_checked, settings, clamped_seen);
      $display("mismatches: %0d, still outstanding: %0d", mismatches, outstanding);
      if (mismatches == 0 && outstanding == 0) begin
         $display("sine_commutation_duty_unit_tb: done, clean");
      end else begin
         $display("sine_commutation_duty_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== sine_commutation_duty_unit.f =====
sv/scd_pkg.sv
sv/scd_channels.sv
sv/scd_wave.sv
sv/scd_xform.sv
sv/scd_divide.sv
sv/sine_commutation_duty_unit.sv
sim/sine_commutation_duty_checker.sv
sim/sine_commutation_duty_unit_tb.sv
